@@ rtl/bcgd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_pkg
// Shared types and constants of the button click gesture decoder.
// ----------------------------------------------------------------------------
package bcgd_pkg;

	// Width of the wrapping time stamps.
	localparam int TIME_BITS = 32;
	localparam int NOW_BITS  = 32;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [TIME_BITS-1:0] stamp_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MENU_MODE     = 3'd0,
		REG_DEBOUNCE      = 3'd1,
		REG_SHORT_MAX     = 3'd2,
		REG_LONG_HOLD     = 3'd3,
		REG_DOUBLE_WINDOW = 3'd4,
		REG_TRIPLE_WINDOW = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_PLAY_PAUSE   = 3'd0,
		EV_NEXT_ITEM    = 3'd1,
		EV_SELECT       = 3'd2,
		EV_MENU         = 3'd3,
		EV_PREV_CHAPTER = 3'd4,
		EV_NEXT_CHAPTER = 3'd5
	} event_t;

	typedef struct packed {
		logic        menu_mode;
		logic [9:0]  debounce_ms;
		logic [13:0] short_max_ms;
		logic [15:0] long_hold_ms;
		logic [13:0] double_window_ms;
		logic [13:0] triple_window_ms;
	} cfg_t;

	localparam logic [9:0]  DEBOUNCE_RST      = 10'd50;
	localparam logic [13:0] SHORT_MAX_RST     = 14'd500;
	localparam logic [15:0] LONG_HOLD_RST     = 16'd1000;
	localparam logic [13:0] DOUBLE_WINDOW_RST = 14'd400;
	localparam logic [13:0] TRIPLE_WINDOW_RST = 14'd400;

	typedef enum logic [6:0] {
		ST_IDLE                = 7'b0000001,
		ST_PRESSED             = 7'b0000010,
		ST_WAIT_DOUBLE         = 7'b0000100,
		ST_WAIT_SECOND_RELEASE = 7'b0001000,
		ST_WAIT_TRIPLE         = 7'b0010000,
		ST_LONG_PRESS          = 7'b0100000,
		ST_WAIT_RELEASE        = 7'b1000000
	} gesture_state_t;

	// Result of one decision step.
	typedef struct packed {
		logic   valid;
		event_t code;
	} ev_res_t;

endpackage : bcgd_pkg
`default_nettype wire

@@ rtl/bcgd_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_cfg
// Configuration register file; each write is truncated to the register width.
// ----------------------------------------------------------------------------
module bcgd_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire  [bcgd_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  wire  [bcgd_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output bcgd_pkg::cfg_t                      cfg
);
	import bcgd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.menu_mode        <= 1'b0;
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.short_max_ms     <= SHORT_MAX_RST;
			cfg_q.long_hold_ms     <= LONG_HOLD_RST;
			cfg_q.double_window_ms <= DOUBLE_WINDOW_RST;
			cfg_q.triple_window_ms <= TRIPLE_WINDOW_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_MENU_MODE:     cfg_q.menu_mode        <= wr_data[0];
				REG_DEBOUNCE:      cfg_q.debounce_ms      <= wr_data[9:0];
				REG_SHORT_MAX:     cfg_q.short_max_ms     <= wr_data[13:0];
				REG_LONG_HOLD:     cfg_q.long_hold_ms     <= wr_data[15:0];
				REG_DOUBLE_WINDOW: cfg_q.double_window_ms <= wr_data[13:0];
				REG_TRIPLE_WINDOW: cfg_q.triple_window_ms <= wr_data[13:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : bcgd_cfg
`default_nettype wire

@@ rtl/bcgd_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_fsm
// Debounce filter and gesture FSM; decides one sample per step-enabled cycle.
// ----------------------------------------------------------------------------
module bcgd_fsm (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      step,
	input  wire                      pin,
	input  wire bcgd_pkg::stamp_t    now,
	input  wire bcgd_pkg::cfg_t      cfg,
	output bcgd_pkg::ev_res_t        res
);
	import bcgd_pkg::*;

	gesture_state_t state_q, state_d;
	stamp_t         stamp_q, stamp_d;
	logic           level_q, level_d;

	logic   pressed;
	logic   is_edge;
	logic   bounce;
	stamp_t stamp_mid;
	stamp_t since_mid;
	stamp_t since_edge;
	event_t short_ev;
	event_t long_ev;

	always_comb begin
		pressed    = !pin;
		is_edge    = (pin != level_q);
		since_edge = now - stamp_q;
		bounce     = is_edge && (since_edge < TIME_BITS'(cfg.debounce_ms));
		stamp_mid  = is_edge ? now : stamp_q;
		since_mid  = now - stamp_mid;
		short_ev   = cfg.menu_mode ? EV_NEXT_ITEM : EV_PLAY_PAUSE;
		long_ev    = cfg.menu_mode ? EV_SELECT : EV_MENU;

		state_d    = state_q;
		stamp_d    = stamp_mid;
		level_d    = is_edge ? pin : level_q;
		res.valid  = 1'b0;
		res.code   = EV_PLAY_PAUSE;

		unique case (state_q)
			ST_PRESSED: begin
				if (!pressed) begin
					// The hold time runs from the press edge, not the release edge.
					if (since_edge < TIME_BITS'(cfg.short_max_ms)) begin
						state_d = ST_WAIT_DOUBLE;
						stamp_d = now;
					end else begin
						res.valid = 1'b1;
						res.code  = short_ev;
						state_d   = ST_IDLE;
					end
				end else if (since_mid >= TIME_BITS'(cfg.long_hold_ms)) begin
					res.valid = 1'b1;
					res.code  = long_ev;
					state_d   = ST_LONG_PRESS;
				end
			end
			ST_WAIT_DOUBLE: begin
				if (pressed) begin
					state_d = ST_WAIT_SECOND_RELEASE;
					stamp_d = now;
				end else if (since_mid >= TIME_BITS'(cfg.double_window_ms)) begin
					res.valid = 1'b1;
					res.code  = short_ev;
					state_d   = ST_IDLE;
				end
			end
			ST_WAIT_SECOND_RELEASE: begin
				if (!pressed) begin
					state_d = ST_WAIT_TRIPLE;
					stamp_d = now;
				end
			end
			ST_WAIT_TRIPLE: begin
				if (pressed) begin
					res.valid = 1'b1;
					res.code  = EV_PREV_CHAPTER;
					state_d   = ST_WAIT_RELEASE;
					stamp_d   = now;
				end else if (since_mid >= TIME_BITS'(cfg.triple_window_ms)) begin
					res.valid = 1'b1;
					res.code  = EV_NEXT_CHAPTER;
					state_d   = ST_IDLE;
				end
			end
			ST_LONG_PRESS, ST_WAIT_RELEASE: begin
				if (!pressed) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = pressed ? ST_PRESSED : ST_IDLE;
			end
		endcase

		// A bounce drops the whole sample and leaves every state bit alone.
		if (bounce) begin
			state_d   = state_q;
			stamp_d   = stamp_q;
			level_d   = level_q;
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stamp_q <= '0;
			level_q <= 1'b1;
		end else if (step) begin
			state_q <= state_d;
			stamp_q <= stamp_d;
			level_q <= level_d;
		end
	end

endmodule : bcgd_fsm
`default_nettype wire

@@ rtl/button_click_gesture_decoder_core.sv @@
`default_nettype none
// An accepted sample is held in the sample register, and its event is loaded
// into the event register once the sample stage advances.
// Throughput: one sample per cycle unless out_stall holds an event; each
// decision is a single state machine pass from sample to event register.
// Reset: arst_n clears the state machine to idle, the edge stamp to zero, the
// settled level to released, and loads the configuration defaults.
// ----------------------------------------------------------------------------
// button_click_gesture_decoder_core
// Debounced single, double, triple and long press decoder with event output.
// ----------------------------------------------------------------------------
module button_click_gesture_decoder_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 pin_level,
	input  wire  [bcgd_pkg::NOW_BITS-1:0]       now_ms,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [2:0]                          event_res,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bcgd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [bcgd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bcgd_pkg::*;

	cfg_t    cfg;
	ev_res_t res;

	logic   valid_s1;
	logic   pin_s1;
	stamp_t now_s1;
	logic   out_valid_q;
	event_t event_q;
	logic   advance;
	logic   in_accept;

	assign cfg_ready = 1'b1;

	bcgd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The sample stage moves on whenever the event register is free or drained.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pin_s1 <= pin_level;
			now_s1 <= TIME_BITS'(now_ms);
		end
	end

	bcgd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.pin    (pin_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			event_q <= res.code;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

endmodule : button_click_gesture_decoder_core
`default_nettype wire

@@ rtl/bcgd_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcgd_chk
// Port-level checks of the gesture decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bcgd_chk (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_stall,
	input wire                                 out_valid,
	input wire                                 out_stall,
	input wire  [2:0]                          event_res,
	input wire                                 cfg_valid,
	input wire                                 cfg_ready
);
	import bcgd_pkg::*;

	// A stalled event transaction keeps its valid and its code.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res))
		else $error("event changed while stalled");

	// Every event code is one of the six defined events.
	a_ev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= 3'(EV_NEXT_CHAPTER))
		else $error("undefined event code");

	// The input side only stalls when a finished event is held back downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// The configuration port never pushes back.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule : bcgd_chk

bind button_click_gesture_decoder_core bcgd_chk u_bcgd_chk (.*);
`default_nettype wire

@@ tb/sv/button_click_gesture_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// button_click_gesture_decoder_core_tb
// Drives timestamped pin samples, with directed gestures first and random
// press sequences after. A sample-level predictor of the debounce filter and
// the gesture state machine runs beside the block, and every event is
// checked against it under several register settings and random stalls.
// ----------------------------------------------------------------------------
module button_click_gesture_decoder_core_tb;
	import bcgd_pkg::*;

	localparam int          PHASES        = 6;
	localparam int          ITEMS         = 1450;
	localparam int          SETTLE_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic   pin;
		stamp_t stamp;
	} sample_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic                     pin_level = 1'b1;
	logic [NOW_BITS-1:0]      now_ms    = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [2:0]               event_res;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	button_click_gesture_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pin_level (pin_level),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sample_t     pending[$];
	event_t      exp_events[$];
	int unsigned errors     = 0;
	int unsigned cycles     = 0;
	int unsigned items_made = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          in_taken   = 1'b0;
	stamp_t      clock_ms   = '0;

	// Predictor state and its copy of the registers.
	gesture_state_t gest_state = ST_IDLE;
	stamp_t         edge_stamp = '0;
	logic           settled    = 1'b1;
	cfg_t           regs;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL button_click_gesture_decoder_core");
			$finish;
		end
	end

	function automatic stamp_t elapsed(input stamp_t now, input stamp_t from);
		return now - from;
	endfunction

	function automatic event_t short_event();
		if (regs.menu_mode)
			return EV_NEXT_ITEM;
		return EV_PLAY_PAUSE;
	endfunction

	task automatic decode_sample(input logic pin, input stamp_t now);
		stamp_t press_stamp;
		logic   pressed;
		press_stamp = edge_stamp;
		pressed = !pin;
		// A level change too soon after the last edge is a bounce and is dropped whole.
		if (pin != settled) begin
			if (elapsed(now, edge_stamp) < regs.debounce_ms)
				return;
			settled = pin;
			edge_stamp = now;
		end
		case (gest_state)
			ST_PRESSED: begin
				if (!pressed) begin
					if (elapsed(now, press_stamp) < regs.short_max_ms) begin
						gest_state = ST_WAIT_DOUBLE;
						edge_stamp = now;
					end else begin
						exp_events.push_back(short_event());
						gest_state = ST_IDLE;
					end
				end else if (elapsed(now, edge_stamp) >= regs.long_hold_ms) begin
					if (regs.menu_mode)
						exp_events.push_back(EV_SELECT);
					else
						exp_events.push_back(EV_MENU);
					gest_state = ST_LONG_PRESS;
				end
			end
			ST_WAIT_DOUBLE: begin
				if (pressed) begin
					gest_state = ST_WAIT_SECOND_RELEASE;
					edge_stamp = now;
				end else if (elapsed(now, edge_stamp) >= regs.double_window_ms) begin
					exp_events.push_back(short_event());
					gest_state = ST_IDLE;
				end
			end
			ST_WAIT_SECOND_RELEASE: begin
				if (!pressed) begin
					gest_state = ST_WAIT_TRIPLE;
					edge_stamp = now;
				end
			end
			ST_WAIT_TRIPLE: begin
				if (pressed) begin
					exp_events.push_back(EV_PREV_CHAPTER);
					gest_state = ST_WAIT_RELEASE;
					edge_stamp = now;
				end else if (elapsed(now, edge_stamp) >= regs.triple_window_ms) begin
					exp_events.push_back(EV_NEXT_CHAPTER);
					gest_state = ST_IDLE;
				end
			end
			ST_LONG_PRESS, ST_WAIT_RELEASE: begin
				if (!pressed)
					gest_state = ST_IDLE;
			end
			default: begin
				if (pressed)
					gest_state = ST_PRESSED;
				else
					gest_state = ST_IDLE;
			end
		endcase
	endtask

	// Sample source: holds a payload until its transaction completes.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				pin_level <= pending[0].pin;
				now_ms    <= pending[0].stamp;
				void'(pending.pop_front());
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		event_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			decode_sample(pin_level, now_ms);
		if (arst_n && out_valid && !out_stall) begin
			if (exp_events.size() == 0) begin
				$error("event_res: no event expected, actual %0d", event_res);
				errors++;
			end else begin
				want = exp_events.pop_front();
				if (event_res !== want) begin
					$error("event_res: expected %0d, actual %0d", want, event_res);
					errors++;
				end
			end
		end
	end

	task automatic add_sample(input logic pin, input int unsigned dt, input bit counted = 1'b1);
		clock_ms += dt;
		pending.push_back('{pin: pin, stamp: clock_ms});
		if (counted)
			items_made++;
	endtask

	// Half the time the limit or one below it, else anywhere up to well past it.
	function automatic int unsigned near(input int unsigned lim);
		case ($urandom_range(0, 3))
			0: return lim;
			1: return (lim > 0) ? lim - 1 : 0;
			default: return $urandom_range(0, lim + lim / 2 + 4);
		endcase
	endfunction

	function automatic int unsigned edge_gap();
		if ($urandom_range(0, 3) == 0)
			return near(regs.debounce_ms);
		return regs.debounce_ms + $urandom_range(0, 30);
	endfunction

	task automatic add_gesture();
		int unsigned presses;
		int unsigned hold;
		int unsigned acc;
		int unsigned d;
		int unsigned window;
		presses = $urandom_range(1, 3);
		for (int k = 0; k < presses; k++) begin
			window = (k < 2) ? regs.double_window_ms : regs.triple_window_ms;
			if (k == 0) begin
				add_sample(1'b0, edge_gap() + $urandom_range(0, 50));
			end else begin
				if ($urandom_range(0, 1) == 0)
					add_sample(1'b1, near(window));
				add_sample(1'b0, near(window));
			end
			if ($urandom_range(0, 3) == 0)
				add_sample(1'b1, $urandom_range(0, regs.debounce_ms), 1'b0);
			if (k == 0 && $urandom_range(0, 3) == 0) begin
				add_sample(1'b0, near(regs.long_hold_ms));
				add_sample(1'b1, $urandom_range(0, 2 * regs.short_max_ms + regs.debounce_ms + 1));
			end else begin
				hold = near(regs.short_max_ms);
				acc = 0;
				repeat ($urandom_range(0, 2)) begin
					d = $urandom_range(0, hold - acc);
					add_sample(1'b0, d);
					acc += d;
				end
				add_sample(1'b1, hold - acc);
			end
		end
		window = (presses == 1) ? regs.double_window_ms : regs.triple_window_ms;
		repeat ($urandom_range(0, 2))
			add_sample(1'b1, near(window));
	endtask

	task automatic add_noise();
		if ($urandom_range(0, 7) == 0)
			clock_ms = $urandom;
		add_sample(1'($urandom_range(0, 1)), $urandom_range(0, 2 * regs.debounce_ms + 20));
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no gap.
	task automatic write_reg(input int unsigned idx, input int unsigned data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_BITS'(idx);
		cfg_data  <= CFG_DATA_BITS'(data);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (CFG_IDX_BITS'(idx))
			REG_MENU_MODE:     regs.menu_mode        = data[0];
			REG_DEBOUNCE:      regs.debounce_ms      = data[9:0];
			REG_SHORT_MAX:     regs.short_max_ms     = data[13:0];
			REG_LONG_HOLD:     regs.long_hold_ms     = data[15:0];
			REG_DOUBLE_WINDOW: regs.double_window_ms = data[13:0];
			REG_TRIPLE_WINDOW: regs.triple_window_ms = data[13:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input int unsigned menu, deb, shrt, lng, dwin, twin);
		write_reg(REG_MENU_MODE, menu);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_SHORT_MAX, shrt);
		write_reg(REG_LONG_HOLD, lng);
		write_reg(REG_DOUBLE_WINDOW, dwin);
		write_reg(REG_TRIPLE_WINDOW, twin);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() != 0 || in_valid || exp_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned target;
		regs = '{menu_mode: 1'b0, debounce_ms: DEBOUNCE_RST, short_max_ms: SHORT_MAX_RST,
			long_hold_ms: LONG_HOLD_RST, double_window_ms: DOUBLE_WINDOW_RST,
			triple_window_ms: TRIPLE_WINDOW_RST};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct  = 21;
					recv_stall_pct = 78;
				end
				1: begin
					send_idle_pct  = 78;
					recv_stall_pct = 21;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (phase)
				0: begin
					// Single with a bounce, double, triple, long, medium, and a
					// short press across the time stamp wrap.
					add_sample(1'b0, 1000); add_sample(1'b1, 20, 1'b0);
					add_sample(1'b1, 180);  add_sample(1'b1, 400);
					add_sample(1'b0, 100);  add_sample(1'b1, 100);
					add_sample(1'b0, 399);  add_sample(1'b1, 60);
					add_sample(1'b1, 400);
					add_sample(1'b0, 100);  add_sample(1'b1, 100);
					add_sample(1'b0, 100);  add_sample(1'b1, 100);
					add_sample(1'b0, 100);  add_sample(1'b1, 100);
					add_sample(1'b0, 100);  add_sample(1'b0, 999);
					add_sample(1'b0, 1);    add_sample(1'b1, 200);
					add_sample(1'b0, 100);  add_sample(1'b1, 500);
					clock_ms = '1;
					add_sample(1'b0, 0);    add_sample(1'b1, 384);
					add_sample(1'b1, 400);
				end
				1: set_all(1, $urandom_range(0, 100), $urandom_range(50, 1000),
					$urandom_range(100, 3000), $urandom_range(50, 1000), $urandom_range(50, 1000));
				2: set_all(0, 1000, 10000, 60000, 10000, 10000);
				3: set_all(1, 0, 0, 0, 0, 0);
				4: begin
					// Full-width data, and the indexes past the last register.
					for (int idx = REG_TRIPLE_WINDOW + 1; idx < 2 ** CFG_IDX_BITS; idx++)
						write_reg(idx, $urandom_range(0, 16'hFFFF));
					set_all($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
						$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
						$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
				end
				default: set_all($urandom_range(0, 1), $urandom_range(0, 60),
					$urandom_range(0, 800), $urandom_range(0, 2000),
					$urandom_range(0, 600), $urandom_range(0, 600));
			endcase
			target = items_made + ITEMS / PHASES;
			while (items_made < target) begin
				if ($urandom_range(0, 99) < 85)
					add_gesture();
				else
					add_noise();
			end
			drain();
		end

		if (exp_events.size() != 0) begin
			$error("event_res: %0d expected events never arrived", exp_events.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS button_click_gesture_decoder_core");
		else
			$display("FAIL button_click_gesture_decoder_core");
		$finish;
	end

endmodule

@@ button_click_gesture_decoder_core.f @@
rtl/bcgd_pkg.sv
rtl/bcgd_cfg.sv
rtl/bcgd_fsm.sv
rtl/button_click_gesture_decoder_core.sv
rtl/bcgd_chk.sv
tb/sv/button_click_gesture_decoder_core_tb.sv
